>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define SBBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pool check failed");

// Next-cycle implication, disabled while reset is held low.
`define SBBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pool check failed");

`endif

>>> hw/rtl/sbbp_pkg.sv
package sbbp_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam logic [31:0] MAX_BYTES_RST = 32'd2097152;

    localparam int KIND_W   = 2;
    localparam int EVENT_W  = 3;
    localparam int FMT_W    = 16;
    localparam int DIM_W    = 14;
    localparam int BYTES_W  = 32;
    localparam int HANDLE_W = 16;
    localparam int KEY_W    = 2 * DIM_W + FMT_W;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 48;

    localparam int S_FMT_LSB    = 0;
    localparam int S_WIDTH_LSB  = S_FMT_LSB + FMT_W;
    localparam int S_HEIGHT_LSB = S_WIDTH_LSB + DIM_W;
    localparam int S_BYTES_LSB  = S_HEIGHT_LSB + DIM_W;
    localparam int S_HANDLE_LSB = S_BYTES_LSB + BYTES_W;

    localparam logic [KIND_W-1:0] KIND_TAKE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETURN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [EVENT_W-1:0] EV_HIT     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_MISS    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_STORED  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_REFUSED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_EVICT   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_CLEAR   = 3'd5;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [FMT_W-1:0]    format;
    } entry_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
        logic                last;
    } result_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_TAKE  = 8'b0000_0010,
        ST_CLEAR = 8'b0000_0100,
        ST_RCHK  = 8'b0000_1000,
        ST_RSCAN = 8'b0001_0000,
        ST_RDEC  = 8'b0010_0000,
        ST_STORE = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    function automatic key_t key_of(entry_t e);
        return {e.width, e.height, e.format};
    endfunction

endpackage

>>> hw/rtl/sbbp_store.sv
module sbbp_store #(
    parameter int ENTRIES = sbbp_pkg::ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(ENTRIES)-1:0] waddr,
    input  sbbp_pkg::entry_t           wdata,
    input  logic                       re,
    input  logic [$clog2(ENTRIES)-1:0] raddr,
    output sbbp_pkg::entry_t           rdata
);

    sbbp_pkg::entry_t slot_mem [ENTRIES];
    sbbp_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            slot_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= slot_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sbbp_cmp.sv
module sbbp_cmp (
    input  sbbp_pkg::key_t     cand_key,
    input  sbbp_pkg::key_t     ref_key,
    output sbbp_pkg::cmp_res_t res
);

    assign res.eq = (cand_key == ref_key);
    assign res.lt = (cand_key < ref_key);

endmodule

>>> hw/rtl/sbbp_ctrl.sv
module sbbp_ctrl #(
    parameter int ENTRIES = sbbp_pkg::ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [sbbp_pkg::BYTES_W-1:0]     max_bytes,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sbbp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [sbbp_pkg::KIND_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output sbbp_pkg::result_t                result,
    output logic                             mem_we,
    output logic [$clog2(ENTRIES)-1:0]       mem_waddr,
    output sbbp_pkg::entry_t                 mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(ENTRIES)-1:0]       mem_raddr,
    input  sbbp_pkg::entry_t                 mem_rdata,
    output sbbp_pkg::key_t                   cand_key,
    output sbbp_pkg::key_t                   ref_key,
    input  sbbp_pkg::cmp_res_t               cmp_res
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int BW    = sbbp_pkg::BYTES_W;

    sbbp_pkg::state_t  state_reg, state_next;
    sbbp_pkg::state_t  ret_reg, ret_next;
    sbbp_pkg::entry_t  req_reg, req_next;
    sbbp_pkg::result_t out_reg, out_next;
    logic [BW-1:0]      used_reg, used_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic               best_found_reg, best_found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    sbbp_pkg::key_t     best_key_reg, best_key_next;
    logic [BW-1:0]      best_bytes_reg, best_bytes_next;
    logic [sbbp_pkg::HANDLE_W-1:0] best_handle_reg, best_handle_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;

    sbbp_pkg::entry_t s_entry;
    logic             scan_issue;
    logic             scan_done;
    logic             cand_valid;
    logic             over_budget;

    assign s_entry.format = s_tdata[sbbp_pkg::S_FMT_LSB +: sbbp_pkg::FMT_W];
    assign s_entry.width  = s_tdata[sbbp_pkg::S_WIDTH_LSB +: sbbp_pkg::DIM_W];
    assign s_entry.height = s_tdata[sbbp_pkg::S_HEIGHT_LSB +: sbbp_pkg::DIM_W];
    assign s_entry.bytes  = s_tdata[sbbp_pkg::S_BYTES_LSB +: sbbp_pkg::BYTES_W];
    assign s_entry.handle = s_tdata[sbbp_pkg::S_HANDLE_LSB +: sbbp_pkg::HANDLE_W];

    assign scan_issue = (idx_reg < CNT_W'(ENTRIES));
    assign scan_done  = !scan_issue && !pend_reg;
    assign cand_valid = pend_reg && valid_reg[pidx_reg];
    assign over_budget = ({1'b0, used_reg} + {1'b0, req_reg.bytes}) > {1'b0, max_bytes};

    assign cand_key = sbbp_pkg::key_of(mem_rdata);
    assign ref_key  = (state_reg == sbbp_pkg::ST_TAKE) ? sbbp_pkg::key_of(req_reg)
                                                       : best_key_reg;

    assign mem_raddr = idx_reg[IDX_W-1:0];
    assign mem_waddr = slot_reg;
    assign mem_wdata = req_reg;

    assign s_tready = (state_reg == sbbp_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sbbp_pkg::ST_EMIT);
    assign result   = out_reg;

    always_comb begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        req_next         = req_reg;
        out_next         = out_reg;
        used_next        = used_reg;
        valid_next       = valid_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        pidx_next        = pidx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_key_next    = best_key_reg;
        best_bytes_next  = best_bytes_reg;
        best_handle_next = best_handle_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        slot_next        = slot_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        unique case (state_reg)
            sbbp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    req_next        = s_entry;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    unique case (s_tuser)
                        sbbp_pkg::KIND_TAKE:   state_next = sbbp_pkg::ST_TAKE;
                        sbbp_pkg::KIND_RETURN: state_next = sbbp_pkg::ST_RCHK;
                        sbbp_pkg::KIND_CLEAR:  state_next = sbbp_pkg::ST_CLEAR;
                        default:               state_next = sbbp_pkg::ST_IDLE;
                    endcase
                end
            end

            sbbp_pkg::ST_TAKE: begin
                mem_re    = scan_issue;
                idx_next  = scan_issue ? idx_reg + CNT_W'(1) : idx_reg;
                pend_next = scan_issue;
                pidx_next = idx_reg[IDX_W-1:0];
                if (cand_valid && cmp_res.eq) begin
                    valid_next[pidx_reg] = 1'b0;
                    used_next  = used_reg - mem_rdata.bytes;
                    out_next   = '{event_res: sbbp_pkg::EV_HIT, handle: mem_rdata.handle,
                                   bytes: mem_rdata.bytes, last: 1'b1};
                    ret_next   = sbbp_pkg::ST_IDLE;
                    state_next = sbbp_pkg::ST_EMIT;
                end else if (scan_done) begin
                    out_next   = '{event_res: sbbp_pkg::EV_MISS, handle: '0,
                                   bytes: '0, last: 1'b1};
                    ret_next   = sbbp_pkg::ST_IDLE;
                    state_next = sbbp_pkg::ST_EMIT;
                end
            end

            sbbp_pkg::ST_CLEAR: begin
                mem_re    = scan_issue;
                idx_next  = scan_issue ? idx_reg + CNT_W'(1) : idx_reg;
                pend_next = scan_issue;
                pidx_next = idx_reg[IDX_W-1:0];
                if (cand_valid) begin
                    // evict, then rewind the scan to the slot after this one
                    valid_next[pidx_reg] = 1'b0;
                    used_next  = used_reg - mem_rdata.bytes;
                    out_next   = '{event_res: sbbp_pkg::EV_EVICT, handle: mem_rdata.handle,
                                   bytes: mem_rdata.bytes, last: 1'b0};
                    idx_next   = CNT_W'(pidx_reg) + CNT_W'(1);
                    pend_next  = 1'b0;
                    ret_next   = sbbp_pkg::ST_CLEAR;
                    state_next = sbbp_pkg::ST_EMIT;
                end else if (scan_done) begin
                    used_next  = '0;
                    out_next   = '{event_res: sbbp_pkg::EV_CLEAR, handle: '0,
                                   bytes: '0, last: 1'b1};
                    ret_next   = sbbp_pkg::ST_IDLE;
                    state_next = sbbp_pkg::ST_EMIT;
                end
            end

            sbbp_pkg::ST_RCHK: begin
                if (req_reg.bytes >= max_bytes) begin
                    out_next   = '{event_res: sbbp_pkg::EV_REFUSED, handle: '0,
                                   bytes: req_reg.bytes, last: 1'b1};
                    ret_next   = sbbp_pkg::ST_IDLE;
                    state_next = sbbp_pkg::ST_EMIT;
                end else begin
                    state_next = sbbp_pkg::ST_RSCAN;
                end
            end

            sbbp_pkg::ST_RSCAN: begin
                mem_re    = scan_issue;
                idx_next  = scan_issue ? idx_reg + CNT_W'(1) : idx_reg;
                pend_next = scan_issue;
                pidx_next = idx_reg[IDX_W-1:0];
                if (cand_valid && (!best_found_reg || cmp_res.lt)) begin
                    best_found_next  = 1'b1;
                    best_idx_next    = pidx_reg;
                    best_key_next    = cand_key;
                    best_bytes_next  = mem_rdata.bytes;
                    best_handle_next = mem_rdata.handle;
                end
                if (pend_reg && !valid_reg[pidx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = pidx_reg;
                end
                if (scan_done) begin
                    state_next = sbbp_pkg::ST_RDEC;
                end
            end

            sbbp_pkg::ST_RDEC: begin
                idx_next        = '0;
                pend_next       = 1'b0;
                best_found_next = 1'b0;
                free_found_next = 1'b0;
                if (over_budget && best_found_reg) begin
                    valid_next[best_idx_reg] = 1'b0;
                    used_next  = used_reg - best_bytes_reg;
                    out_next   = '{event_res: sbbp_pkg::EV_EVICT, handle: best_handle_reg,
                                   bytes: best_bytes_reg, last: 1'b0};
                    ret_next   = sbbp_pkg::ST_RSCAN;
                    state_next = sbbp_pkg::ST_EMIT;
                end else if (over_budget || free_found_reg) begin
                    slot_next  = free_idx_reg;
                    state_next = sbbp_pkg::ST_STORE;
                end else begin
                    // table full: drop the smallest key and reuse its slot
                    valid_next[best_idx_reg] = 1'b0;
                    used_next  = used_reg - best_bytes_reg;
                    out_next   = '{event_res: sbbp_pkg::EV_EVICT, handle: best_handle_reg,
                                   bytes: best_bytes_reg, last: 1'b0};
                    slot_next  = best_idx_reg;
                    ret_next   = sbbp_pkg::ST_STORE;
                    state_next = sbbp_pkg::ST_EMIT;
                end
            end

            sbbp_pkg::ST_STORE: begin
                mem_we               = 1'b1;
                valid_next[slot_reg] = 1'b1;
                used_next  = used_reg + req_reg.bytes;
                out_next   = '{event_res: sbbp_pkg::EV_STORED, handle: req_reg.handle,
                               bytes: req_reg.bytes, last: 1'b1};
                ret_next   = sbbp_pkg::ST_IDLE;
                state_next = sbbp_pkg::ST_EMIT;
            end

            sbbp_pkg::ST_EMIT: begin
                if (m_tready) begin
                    state_next = ret_reg;
                end
            end

            default: begin
                state_next = sbbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sbbp_pkg::ST_IDLE;
            ret_reg        <= sbbp_pkg::ST_IDLE;
            used_reg       <= '0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            used_reg       <= used_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        out_reg         <= out_next;
        pidx_reg        <= pidx_next;
        best_idx_reg    <= best_idx_next;
        best_key_reg    <= best_key_next;
        best_bytes_reg  <= best_bytes_next;
        best_handle_reg <= best_handle_next;
        free_idx_reg    <= free_idx_next;
        slot_reg        <= slot_next;
    end

endmodule

>>> hw/rtl/size_budget_buffer_pool.sv
// Buffer pool with a byte budget, keyed by (width, height, format).
// Input words (s_*): s_tuser picks the request: take, return or clear.
//   A take yields one word: hit (handle, bytes) or miss.
//   A return yields zero or more evicted-entry words, then one stored or
//   refused word with m_tlast set. A clear yields one evicted-entry word per
//   pooled buffer, then a clear-done word with m_tlast set.
// Output words (m_*) carry the event code in m_tuser.
// The budget register is written through cfg_we / cfg_wdata; the user must
// write it only while idle, since the block itself does not enforce this.
// One request at a time: s_tready is high only while idle. Take and return
// searches walk the slot table through one shared key comparator at one slot
// per cycle while no word waits, reading a memory with one read and one write
// port. A refused return answers without a search; other returns evict the
// smallest key and search again while over budget, and a full table drops its
// smallest key to free a slot; a clear evicts each pooled buffer in turn.
// Every word waits in the output register until m_tready; the search halts
// meanwhile, so a stalled receiver only delays the answers.
// Reset (aresetn low, synchronous) empties the pool, zeroes the byte total
// and restores the budget to 2 MiB; no clearing pass is needed.
module size_budget_buffer_pool #(
    parameter int ENTRIES = sbbp_pkg::ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sbbp_pkg::BYTES_W-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // format[15:0], width[29:16], height[43:30], bytes[75:44], handle[91:76]
    input  logic [sbbp_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [sbbp_pkg::KIND_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // handle[15:0], bytes[47:16]
    output logic [sbbp_pkg::M_TDATA_W-1:0] m_tdata,
    // event_res[2:0]
    output logic [sbbp_pkg::EVENT_W-1:0]   m_tuser,
    output logic                           m_tlast
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [sbbp_pkg::BYTES_W-1:0] max_bytes_reg;
    sbbp_pkg::result_t             result;
    logic                          mem_we;
    logic                          mem_re;
    logic [IDX_W-1:0]              mem_waddr;
    logic [IDX_W-1:0]              mem_raddr;
    sbbp_pkg::entry_t              mem_wdata;
    sbbp_pkg::entry_t              mem_rdata;
    sbbp_pkg::key_t                cand_key;
    sbbp_pkg::key_t                ref_key;
    sbbp_pkg::cmp_res_t            cmp_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= sbbp_pkg::MAX_BYTES_RST;
        end else if (cfg_we) begin
            max_bytes_reg <= cfg_wdata;
        end
    end

    sbbp_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sbbp_cmp u_cmp (
        .cand_key (cand_key),
        .ref_key  (ref_key),
        .res      (cmp_res)
    );

    sbbp_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_bytes (max_bytes_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .cand_key  (cand_key),
        .ref_key   (ref_key),
        .cmp_res   (cmp_res)
    );

    assign m_tdata = {result.bytes, result.handle};
    assign m_tuser = result.event_res;
    assign m_tlast = result.last;

endmodule

>>> hw/rtl/sbbp_checker.sv
`include "assert_macros.svh"

module sbbp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic [sbbp_pkg::BYTES_W-1:0]   cfg_wdata,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sbbp_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [sbbp_pkg::KIND_W-1:0]    s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sbbp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sbbp_pkg::EVENT_W-1:0]   m_tuser,
    input logic                           m_tlast
);

    logic undef_kind_acc;

    assign undef_kind_acc = s_tvalid && s_tready && (s_tuser != sbbp_pkg::KIND_TAKE)
                            && (s_tuser != sbbp_pkg::KIND_RETURN)
                            && (s_tuser != sbbp_pkg::KIND_CLEAR);

    `SBBP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `SBBP_ASSERT_SAME(a_one_request, aclk, aresetn, m_tvalid, !s_tready)
    `SBBP_ASSERT_SAME(a_evict_not_last, aclk, aresetn, m_tvalid && (m_tuser == sbbp_pkg::EV_EVICT), !m_tlast)
    `SBBP_ASSERT_SAME(a_empty_words, aclk, aresetn, m_tvalid && ((m_tuser == sbbp_pkg::EV_MISS) || (m_tuser == sbbp_pkg::EV_CLEAR)), (m_tdata == '0) && m_tlast)
    `SBBP_ASSERT_NEXT(a_undef_kind_idle, aclk, aresetn, undef_kind_acc && !cfg_we && (cfg_wdata == cfg_wdata), s_tready && !m_tvalid)

endmodule

bind size_budget_buffer_pool sbbp_checker u_sbbp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

>>> test/pool_checker.sv
`timescale 1ns / 1ps

module pool_checker #(
    parameter int ENTRIES = sbbp_pkg::ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sbbp_pkg::BYTES_W-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sbbp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [sbbp_pkg::KIND_W-1:0]    s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sbbp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [sbbp_pkg::EVENT_W-1:0]   m_tuser,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             words_due
);
    import sbbp_pkg::*;

    logic [BYTES_W-1:0]  budget;
    logic [BYTES_W-1:0]  used_total;
    logic                live      [ENTRIES];
    logic [DIM_W-1:0]    slot_w    [ENTRIES];
    logic [DIM_W-1:0]    slot_h    [ENTRIES];
    logic [FMT_W-1:0]    slot_f    [ENTRIES];
    logic [BYTES_W-1:0]  slot_size [ENTRIES];
    logic [HANDLE_W-1:0] slot_id   [ENTRIES];
    result_t             due_words [$];

    initial begin
        fail_count = 0;
        words_due = 0;
    end

    task automatic note_mismatch(input string msg);
        if (fail_count < 100) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic key_t slot_key(input int s);
        return {slot_w[s], slot_h[s], slot_f[s]};
    endfunction

    function automatic int smallest_live();
        int pick;
        int s;
        pick = -1;
        for (s = 0; s < ENTRIES; s++) begin
            if (live[s] && (pick < 0 || slot_key(s) < slot_key(pick))) begin
                pick = s;
            end
        end
        return pick;
    endfunction

    task automatic expect_word(input logic [EVENT_W-1:0] ev, input logic [HANDLE_W-1:0] hd,
                               input logic [BYTES_W-1:0] nb, input logic lst);
        result_t r;
        r.event_res = ev;
        r.handle = hd;
        r.bytes = nb;
        r.last = lst;
        due_words.push_back(r);
    endtask

    task automatic drop_slot(input int s);
        live[s] = 1'b0;
        used_total = used_total - slot_size[s];
        expect_word(EV_EVICT, slot_id[s], slot_size[s], 1'b0);
    endtask

    task automatic serve_request(input logic [KIND_W-1:0] kind, input logic [FMT_W-1:0] fmt,
                                 input logic [DIM_W-1:0] wd, input logic [DIM_W-1:0] ht,
                                 input logic [BYTES_W-1:0] nb, input logic [HANDLE_W-1:0] hd);
        int s;
        int pick;
        pick = -1;
        case (kind)
            KIND_TAKE: begin
                for (s = 0; s < ENTRIES; s++) begin
                    if (pick < 0 && live[s] && slot_w[s] == wd && slot_h[s] == ht
                        && slot_f[s] == fmt) begin
                        pick = s;
                    end
                end
                if (pick >= 0) begin
                    live[pick] = 1'b0;
                    used_total = used_total - slot_size[pick];
                    expect_word(EV_HIT, slot_id[pick], slot_size[pick], 1'b1);
                end else begin
                    expect_word(EV_MISS, '0, '0, 1'b1);
                end
            end
            KIND_RETURN: begin
                if (nb >= budget) begin
                    expect_word(EV_REFUSED, '0, nb, 1'b1);
                end else begin
                    while ({1'b0, used_total} + {1'b0, nb} > {1'b0, budget}) begin
                        pick = smallest_live();
                        if (pick < 0) break;
                        drop_slot(pick);
                    end
                    pick = -1;
                    for (s = ENTRIES - 1; s >= 0; s--) begin
                        if (!live[s]) pick = s;
                    end
                    if (pick < 0) begin
                        pick = smallest_live();
                        drop_slot(pick);
                    end
                    live[pick] = 1'b1;
                    slot_w[pick] = wd;
                    slot_h[pick] = ht;
                    slot_f[pick] = fmt;
                    slot_size[pick] = nb;
                    slot_id[pick] = hd;
                    used_total = used_total + nb;
                    expect_word(EV_STORED, hd, nb, 1'b1);
                end
            end
            KIND_CLEAR: begin
                for (s = 0; s < ENTRIES; s++) begin
                    if (live[s]) drop_slot(s);
                end
                used_total = '0;
                expect_word(EV_CLEAR, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_word();
        result_t want;
        if (due_words.size() == 0) begin
            note_mismatch($sformatf("word with no request behind it, event %0d handle %0h",
                                    m_tuser, m_tdata[HANDLE_W-1:0]));
        end else begin
            want = due_words.pop_front();
            if (m_tuser !== want.event_res)
                note_mismatch($sformatf("event got %0d want %0d", m_tuser, want.event_res));
            if (m_tdata[HANDLE_W-1:0] !== want.handle)
                note_mismatch($sformatf("handle got %0h want %0h",
                                        m_tdata[HANDLE_W-1:0], want.handle));
            if (m_tdata[HANDLE_W +: BYTES_W] !== want.bytes)
                note_mismatch($sformatf("bytes got %0h want %0h",
                                        m_tdata[HANDLE_W +: BYTES_W], want.bytes));
            if (m_tlast !== want.last)
                note_mismatch($sformatf("last got %0b want %0b", m_tlast, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            budget = MAX_BYTES_RST;
            used_total = '0;
            for (int s = 0; s < ENTRIES; s++) live[s] = 1'b0;
            due_words.delete();
        end else begin
            if (cfg_we) budget = cfg_wdata;
            if (m_tvalid && m_tready) check_word();
            if (s_tvalid && s_tready) begin
                serve_request(s_tuser, s_tdata[S_FMT_LSB +: FMT_W],
                              s_tdata[S_WIDTH_LSB +: DIM_W], s_tdata[S_HEIGHT_LSB +: DIM_W],
                              s_tdata[S_BYTES_LSB +: BYTES_W],
                              s_tdata[S_HANDLE_LSB +: HANDLE_W]);
            end
        end
        words_due = due_words.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sbbp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int SETTLE = 2 * ENTRIES_DEF + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int PAD_W = S_TDATA_W - S_HANDLE_LSB - HANDLE_W;

    typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} press_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [BYTES_W-1:0]    cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [EVENT_W-1:0]    m_tuser;
    logic                  m_tlast;

    int                    fail_count;
    int                    words_due;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_req = 0;
    int                    hold_seen = 0;
    logic [BYTES_W-1:0]    budget_now;
    int                    requests = 0;
    logic [DIM_W-1:0]      pool_w [8];
    logic [DIM_W-1:0]      pool_h [8];
    logic [FMT_W-1:0]      pool_f [8];

    size_budget_buffer_pool dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    pool_checker #(.ENTRIES(ENTRIES_DEF)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("[size_budget_buffer_pool] ERROR");
        $finish;
    end

    task automatic offer(input logic [KIND_W-1:0] kind, input logic [FMT_W-1:0] fmt,
                         input logic [DIM_W-1:0] wd, input logic [DIM_W-1:0] ht,
                         input logic [BYTES_W-1:0] nb, input logic [HANDLE_W-1:0] hd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{PAD_W{1'b0}}, hd, nb, ht, wd, fmt};
        do @(posedge aclk); while (!s_tready);
        if (kind != KIND_NONE) requests++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
    endtask

    task automatic set_budget(input logic [BYTES_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        budget_now = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic refresh_keys();
        pool_w[0] = '0;
        pool_h[0] = '0;
        pool_f[0] = '0;
        pool_w[1] = '1;
        pool_h[1] = '1;
        pool_f[1] = '1;
        for (int k = 2; k < 8; k++) begin
            pool_w[k] = (k < 6) ? DIM_W'($urandom_range(3)) : DIM_W'($urandom);
            pool_h[k] = (k < 6) ? DIM_W'($urandom_range(3)) : DIM_W'($urandom);
            pool_f[k] = (k < 6) ? FMT_W'($urandom_range(3)) : FMT_W'($urandom);
        end
    endtask

    task automatic random_request(input int take_pct);
        int                 r;
        int                 k;
        logic [KIND_W-1:0]  kind;
        logic [FMT_W-1:0]   fmt;
        logic [DIM_W-1:0]   wd;
        logic [DIM_W-1:0]   ht;
        logic [BYTES_W-1:0] nb;
        r = $urandom_range(99);
        if (r < take_pct) kind = KIND_TAKE;
        else if (r < take_pct + 4) kind = KIND_CLEAR;
        else if (r < take_pct + 6) kind = KIND_NONE;
        else kind = KIND_RETURN;
        k = $urandom_range(7);
        if ($urandom_range(99) < 85) begin
            wd = pool_w[k];
            ht = pool_h[k];
            fmt = pool_f[k];
        end else begin
            wd = DIM_W'($urandom);
            ht = DIM_W'($urandom);
            fmt = FMT_W'($urandom);
        end
        r = $urandom_range(99);
        if (r < 30) nb = $urandom_range(255);
        else if (r < 65) nb = $urandom_range(budget_now / 5);
        else if (r < 80) nb = (budget_now == 0) ? '0 : $urandom_range(budget_now - 1);
        else if (r < 87) nb = budget_now - 1;
        else if (r < 93) nb = budget_now;
        else nb = $urandom;
        offer(kind, fmt, wd, ht, nb, HANDLE_W'($urandom));
    endtask

    task automatic run_phase(input logic [BYTES_W-1:0] value, input int count,
                             input int s_idle, input int r_idle, input int take_pct,
                             input press_t press);
        int  start;
        bit  pressed;
        pressed = 1'b0;
        set_budget(value);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        refresh_keys();
        start = requests;
        while (requests - start < count) begin
            if (!pressed && requests - start >= count / 2) begin
                pressed = 1'b1;
                if (press == PRESS_HOLD) hold_req++;
                if (press == PRESS_PAUSE) wait_drained();
            end
            random_request(take_pct);
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_TAKE;
        budget_now = MAX_BYTES_RST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(KIND_TAKE, '0, '0, '0, '0, '0);
        offer(KIND_CLEAR, '0, '0, '0, '0, '0);
        offer(KIND_NONE, '1, '1, '1, '1, '1);
        offer(KIND_RETURN, '1, '1, '1, '1, '1);
        offer(KIND_RETURN, 16'd3, 14'd3, 14'd3, MAX_BYTES_RST, 16'h0101);
        offer(KIND_RETURN, '0, '0, '0, '0, '0);
        offer(KIND_RETURN, '1, '1, '1, MAX_BYTES_RST - 1, '1);
        offer(KIND_RETURN, 16'd7, 14'd5, 14'd5, 32'd1000, 16'h1234);
        offer(KIND_RETURN, 16'd7, 14'd5, 14'd5, 32'd2000, 16'h5678);
        offer(KIND_TAKE, 16'd7, 14'd5, 14'd5, '0, '0);
        offer(KIND_RETURN, 16'd6, 14'd5, 14'd5, 32'd3000, 16'haaaa);
        offer(KIND_RETURN, 16'hffff, 14'd5, 14'd4, 32'd10, 16'h5555);
        offer(KIND_RETURN, 16'hffff, 14'd4, 14'h3fff, 32'd10, 16'h0f0f);
        set_budget(32'd2500);
        offer(KIND_RETURN, 16'd9, 14'd9, 14'd9, 32'd100, 16'h0099);
        offer(KIND_TAKE, 16'd6, 14'd5, 14'd5, '0, '0);
        offer(KIND_TAKE, 16'd9, 14'd9, 14'd9, '0, '0);
        offer(KIND_CLEAR, '0, '0, '0, '0, '0);
        set_budget('1);
        offer(KIND_RETURN, 16'd1, 14'd2, 14'd3, 32'hffff_fffe, 16'hc0de);
        offer(KIND_RETURN, 16'd1, 14'd2, 14'd3, 32'hffff_fffe, 16'hbeef);
        offer(KIND_CLEAR, '0, '0, '0, '0, '0);

        run_phase(MAX_BYTES_RST, 75, 11, 50, 40, PRESS_HOLD);
        run_phase(32'd4096, 75, 11, 50, 35, PRESS_PAUSE);
        run_phase('1, 75, 50, 11, 15, PRESS_NONE);
        run_phase('0, 20, 50, 11, 40, PRESS_NONE);
        run_phase($urandom, 75, 0, 0, 30, PRESS_NONE);
        run_phase(32'd1 << 20, 75, 0, 0, 20, PRESS_NONE);

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[size_budget_buffer_pool] OK");
        end else begin
            $display("[size_budget_buffer_pool] ERROR");
        end
        $finish;
    end

endmodule
